FILE: design/imuoc_pkg.sv
// shared types and constants for the imu offset calibration block
package imuoc_pkg;

    // axis count and index width
    localparam int unsigned AXES   = 6;
    localparam int unsigned AXIS_W = $clog2(AXES);

    // axis indexes with a special role
    localparam logic [AXIS_W-1:0] AXIS_ACCEL_Z = AXIS_W'(2);
    localparam logic [AXIS_W-1:0] AXIS_LAST    = AXIS_W'(AXES - 1);

    // sample and accumulator widths
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned SUM_W    = 32;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned RANGE_W  = 3;

    // one g at the widest range, before the range shift
    localparam int unsigned ONE_G_W        = 18;
    localparam logic [ONE_G_W-1:0] ONE_G_BASE = ONE_G_W'(1024);

    // register reset values
    localparam logic [COUNT_W-1:0] CALIB_COUNT_RESET = COUNT_W'(100);
    localparam logic [RANGE_W-1:0] RANGE_SEL_RESET   = RANGE_W'(0);

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_CALIB_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_SEL   = 1'b1;

    // shared divider: one quotient bit per step
    localparam int unsigned DIV_STEPS = SUM_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

endpackage

FILE: design/imuoc_div.sv
// shared iterative divider: signed 32-bit sum by unsigned 16-bit count, truncating
module imuoc_div
    import imuoc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [SUM_W-1:0]    dividend,
    input  logic [COUNT_W-1:0]         divisor,
    output logic                       done,
    output logic [SAMPLE_W-1:0]        quotient
);

    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic                  neg_reg, neg_next;
    logic [DIV_CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]      quo_reg, quo_next;
    logic [COUNT_W-1:0]    rem_reg, rem_next;
    logic [COUNT_W-1:0]    div_reg, div_next;

    logic [COUNT_W:0]      rem_shift;
    logic [COUNT_W:0]      rem_diff;
    logic                  fits;

    // one restoring step on the running remainder
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[SUM_W-1]};
        rem_diff  = rem_shift - {1'b0, div_reg};
        fits      = rem_shift >= {1'b0, div_reg};
    end

    // step control and operand load
    always_comb
    begin
        run_next   = run_reg;
        done_next  = 1'b0;
        neg_next   = neg_reg;
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        if (start)
        begin
            run_next   = 1'b1;
            neg_next   = dividend[SUM_W-1];
            count_next = '0;
            quo_next   = dividend[SUM_W-1] ? (SUM_W'(0) - SUM_W'(dividend)) : SUM_W'(dividend);
            rem_next   = '0;
            div_next   = divisor;
        end
        else if (run_reg)
        begin
            quo_next   = {quo_reg[SUM_W-2:0], fits};
            rem_next   = fits ? rem_diff[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
            count_next = count_reg + DIV_CNT_W'(1);
            if (count_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            run_reg   <= run_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // operand registers
    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    // sign fix-up, wrapped to sample width
    assign done     = done_reg;
    assign quotient = neg_reg ? (SAMPLE_W'(0) - quo_reg[SAMPLE_W-1:0]) : quo_reg[SAMPLE_W-1:0];

endmodule

FILE: design/imu_offset_calibrate_compensate.sv
// imu offset calibration and compensation, top level with sequencer
//
// Takes six-axis imu frames on the input channel (in_valid/in_ready) and gives
// offset-compensated frames on the output channel (out_valid/out_ready).
// A frame whose accel x low byte is zero is stale: it is taken and dropped
// with no result. Other frames give one result: raw minus stored offset per
// axis. Calibration frames (kind = 1) also add the compensated values into
// six sums; the frame that completes calib_count of them sets each offset to
// its sum over the count (accel z keeps one g in) and raises calib_done.
// The axes go one per cycle through one subtractor and adder; the result then
// passes through the output step into the result register, and the sequencer
// returns to idle to take the next frame. A completing calibration frame also
// runs the six sums, one axis after another, through one shared divider before
// its result is given.
// One frame is worked on at a time; in_ready is high only while idle, and the
// result register lets the next frame be taken while a result waits.
// If the receiver stalls, the sequencer holds in its last step until the
// result register is free. Reset clears offsets, sums, counter and sets the
// configuration registers to their defaults (count 100, range select 0).
module imu_offset_calibrate_compensate
    import imuoc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration write port
    input  logic                        cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    // input channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        kind,
    input  logic signed [SAMPLE_W-1:0]  accel_x_raw,
    input  logic signed [SAMPLE_W-1:0]  accel_y_raw,
    input  logic signed [SAMPLE_W-1:0]  accel_z_raw,
    input  logic signed [SAMPLE_W-1:0]  gyro_x_raw,
    input  logic signed [SAMPLE_W-1:0]  gyro_y_raw,
    input  logic signed [SAMPLE_W-1:0]  gyro_z_raw,
    // output channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [SAMPLE_W-1:0]  accel_x_comp,
    output logic signed [SAMPLE_W-1:0]  accel_y_comp,
    output logic signed [SAMPLE_W-1:0]  accel_z_comp,
    output logic signed [SAMPLE_W-1:0]  gyro_x_comp,
    output logic signed [SAMPLE_W-1:0]  gyro_y_comp,
    output logic signed [SAMPLE_W-1:0]  gyro_z_comp,
    output logic                        calib_done
);

    state_t                state_reg, state_next;
    logic [AXIS_W-1:0]     axis_reg, axis_next;
    logic                  kind_reg, kind_next;
    logic                  hit_reg, hit_next;
    logic [COUNT_W-1:0]    calib_count_reg, calib_count_next;
    logic [RANGE_W-1:0]    range_sel_reg, range_sel_next;
    logic [COUNT_W-1:0]    seen_reg, seen_next;
    logic [SAMPLE_W-1:0]   offset_reg [AXES];
    logic [SAMPLE_W-1:0]   offset_next [AXES];
    logic [SUM_W-1:0]      sum_reg [AXES];
    logic [SUM_W-1:0]      sum_next [AXES];
    logic [SAMPLE_W-1:0]   raw_reg [AXES];
    logic [SAMPLE_W-1:0]   raw_next [AXES];
    logic [SAMPLE_W-1:0]   comp_reg [AXES];
    logic [SAMPLE_W-1:0]   comp_next [AXES];
    logic                  out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]   out_comp_reg [AXES];
    logic [SAMPLE_W-1:0]   out_comp_next [AXES];
    logic                  out_done_reg, out_done_next;

    logic                  in_xfer;
    logic                  stale;
    logic                  out_free;
    logic [SAMPLE_W-1:0]   comp_axis;
    logic [SUM_W-1:0]      sum_axis;
    logic [COUNT_W-1:0]    divisor;
    logic [COUNT_W-1:0]    seen_inc;
    logic                  calib_hit;
    logic [ONE_G_W-1:0]    one_g_wide;
    logic [SAMPLE_W-1:0]   one_g;
    logic                  div_start;
    logic                  div_done;
    logic [SAMPLE_W-1:0]   div_quotient;

    // shared divider
    imuoc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg[axis_reg]),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // handshake and shared datapath terms
    always_comb
    begin
        in_xfer    = in_valid && (state_reg == ST_IDLE);
        stale      = (accel_x_raw[7:0] == 8'd0);
        out_free   = !out_valid_reg || out_ready;
        comp_axis  = raw_reg[axis_reg] - offset_reg[axis_reg];
        sum_axis   = sum_reg[axis_reg] + {{(SUM_W-SAMPLE_W){comp_axis[SAMPLE_W-1]}}, comp_axis};
        divisor    = (calib_count_reg == '0) ? COUNT_W'(1) : calib_count_reg;
        seen_inc   = seen_reg + COUNT_W'(1);
        calib_hit  = (seen_inc >= divisor) || (seen_inc == '0);
        one_g_wide = ONE_G_BASE << range_sel_reg;
        one_g      = one_g_wide[SAMPLE_W-1:0];
    end

    // sequencer: next state and datapath control
    always_comb
    begin
        state_next       = state_reg;
        axis_next        = axis_reg;
        kind_next        = kind_reg;
        hit_next         = hit_reg;
        calib_count_next = calib_count_reg;
        range_sel_next   = range_sel_reg;
        seen_next        = seen_reg;
        offset_next      = offset_reg;
        sum_next         = sum_reg;
        raw_next         = raw_reg;
        comp_next        = comp_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_comp_next    = out_comp_reg;
        out_done_next    = out_done_reg;
        div_start        = 1'b0;

        // configuration writes
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_CALIB_COUNT: calib_count_next = cfg_data[COUNT_W-1:0];
                CFG_RANGE_SEL:   range_sel_next   = cfg_data[RANGE_W-1:0];
                default:         calib_count_next = calib_count_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                // capture a frame, stale ones are dropped here
                if (in_xfer && !stale)
                begin
                    raw_next[0] = accel_x_raw;
                    raw_next[1] = accel_y_raw;
                    raw_next[2] = accel_z_raw;
                    raw_next[3] = gyro_x_raw;
                    raw_next[4] = gyro_y_raw;
                    raw_next[5] = gyro_z_raw;
                    kind_next   = kind;
                    hit_next    = 1'b0;
                    axis_next   = '0;
                    state_next  = ST_ACC;
                end
            end
            ST_ACC:
            begin
                // one axis per cycle: compensate and accumulate
                comp_next[axis_reg] = comp_axis;
                if (kind_reg)
                begin
                    sum_next[axis_reg] = sum_axis;
                end
                if (axis_reg == AXIS_LAST)
                begin
                    axis_next = '0;
                    if (kind_reg && calib_hit)
                    begin
                        seen_next  = '0;
                        hit_next   = 1'b1;
                        state_next = ST_DIV_START;
                    end
                    else
                    begin
                        if (kind_reg)
                        begin
                            seen_next = seen_inc;
                        end
                        state_next = ST_OUT;
                    end
                end
                else
                begin
                    axis_next = axis_reg + AXIS_W'(1);
                end
            end
            ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                // new offset from the quotient (one g taken off on accel z), sum cleared
                if (div_done)
                begin
                    offset_next[axis_reg] = (axis_reg == AXIS_ACCEL_Z) ?
                                            (div_quotient - one_g) : div_quotient;
                    sum_next[axis_reg]    = '0;
                    if (axis_reg == AXIS_LAST)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        axis_next  = axis_reg + AXIS_W'(1);
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_OUT:
            begin
                // hand the result to the output register once it is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_comp_next  = comp_reg;
                    out_done_next  = hit_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and calibration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            axis_reg        <= '0;
            kind_reg        <= 1'b0;
            hit_reg         <= 1'b0;
            calib_count_reg <= CALIB_COUNT_RESET;
            range_sel_reg   <= RANGE_SEL_RESET;
            seen_reg        <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < AXES; i++)
            begin
                offset_reg[i] <= '0;
                sum_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            axis_reg        <= axis_next;
            kind_reg        <= kind_next;
            hit_reg         <= hit_next;
            calib_count_reg <= calib_count_next;
            range_sel_reg   <= range_sel_next;
            seen_reg        <= seen_next;
            out_valid_reg   <= out_valid_next;
            offset_reg      <= offset_next;
            sum_reg         <= sum_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        raw_reg      <= raw_next;
        comp_reg     <= comp_next;
        out_comp_reg <= out_comp_next;
        out_done_reg <= out_done_next;
    end

    // ports
    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign accel_x_comp = out_comp_reg[0];
    assign accel_y_comp = out_comp_reg[1];
    assign accel_z_comp = out_comp_reg[2];
    assign gyro_x_comp  = out_comp_reg[3];
    assign gyro_y_comp  = out_comp_reg[4];
    assign gyro_z_comp  = out_comp_reg[5];
    assign calib_done   = out_done_reg;

endmodule

FILE: design/imuoc_checker.sv
// port-level checks for the imu offset calibration block, bound to the top level
module imuoc_checker
    import imuoc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic signed [SAMPLE_W-1:0]  accel_x_raw,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic signed [SAMPLE_W-1:0]  accel_x_comp,
    input  logic signed [SAMPLE_W-1:0]  accel_y_comp,
    input  logic signed [SAMPLE_W-1:0]  accel_z_comp,
    input  logic signed [SAMPLE_W-1:0]  gyro_x_comp,
    input  logic signed [SAMPLE_W-1:0]  gyro_y_comp,
    input  logic signed [SAMPLE_W-1:0]  gyro_z_comp,
    input  logic                        calib_done
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(accel_x_comp)
            && $stable(accel_y_comp) && $stable(accel_z_comp) && $stable(gyro_x_comp)
            && $stable(gyro_y_comp) && $stable(gyro_z_comp) && $stable(calib_done))
        else $error("stalled result changed");

    // a stale frame is dropped at once, the block stays ready
    a_stale_drop: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (accel_x_raw[7:0] == 8'd0) |=> in_ready)
        else $error("stale frame not dropped");

    // a fresh frame keeps the block busy for its working steps
    a_fresh_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (accel_x_raw[7:0] != 8'd0) |=> !in_ready ##1 !in_ready)
        else $error("fresh frame did not occupy the block");

    // no result appears in the cycle right after a fresh frame transfer
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (accel_x_raw[7:0] != 8'd0) && !out_valid |=> !out_valid)
        else $error("result appeared before the frame was worked");

endmodule

bind imu_offset_calibrate_compensate imuoc_checker u_imuoc_checker (.*);

FILE: sim/imu_offset_calibrate_compensate_tb.sv
// testbench for the imu offset calibration and compensation block
module imu_offset_calibrate_compensate_tb
    import imuoc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // frame kinds
    localparam logic KIND_MEAS = 1'b0;
    localparam logic KIND_CAL  = 1'b1;

    // cycle counts for the quiet spells, and the random phase sizes
    localparam int SETTLE_CYCLES    = 24;
    localparam int END_CYCLES       = 400;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RANDOM_PHASES    = 12;
    localparam int PHASE_FRAMES     = 86;

    typedef struct packed {
        logic                             kind;
        logic [AXES-1:0][SAMPLE_W-1:0]    raw;
    } frame_t;

    typedef struct packed {
        logic [AXES-1:0][SAMPLE_W-1:0]    comp;
        logic                             done;
    } comp_frame_t;

    // block ports
    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       kind = KIND_MEAS;
    logic signed [SAMPLE_W-1:0] accel_x_raw = '0;
    logic signed [SAMPLE_W-1:0] accel_y_raw = '0;
    logic signed [SAMPLE_W-1:0] accel_z_raw = '0;
    logic signed [SAMPLE_W-1:0] gyro_x_raw = '0;
    logic signed [SAMPLE_W-1:0] gyro_y_raw = '0;
    logic signed [SAMPLE_W-1:0] gyro_z_raw = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] accel_x_comp;
    logic signed [SAMPLE_W-1:0] accel_y_comp;
    logic signed [SAMPLE_W-1:0] accel_z_comp;
    logic signed [SAMPLE_W-1:0] gyro_x_comp;
    logic signed [SAMPLE_W-1:0] gyro_y_comp;
    logic signed [SAMPLE_W-1:0] gyro_z_comp;
    logic                       calib_done;

    // stimulus and scoreboard state
    frame_t       frames_to_send[$];
    comp_frame_t  pending_comp[$];
    frame_t       drive_frame;
    frame_t       taken_frame;
    comp_frame_t  predicted;
    comp_frame_t  want;
    comp_frame_t  got;
    int           frames_queued = 0;
    int           frames_accepted = 0;
    int           mismatch_count = 0;
    logic         in_taken = 1'b0;
    int           in_idle_pct = 0;
    int           out_stall_pct = 0;
    bit           hold_request = 1'b0;
    bit           rx_hold = 1'b0;
    logic [SAMPLE_W-1:0] axis_bias [AXES];
    string        comp_name [AXES] = '{"accel_x_comp", "accel_y_comp", "accel_z_comp",
                                       "gyro_x_comp", "gyro_y_comp", "gyro_z_comp"};

    // predictor copy of the block's registers and state
    logic [COUNT_W-1:0]  count_cfg = CALIB_COUNT_RESET;
    logic [RANGE_W-1:0]  range_cfg = RANGE_SEL_RESET;
    logic [SAMPLE_W-1:0] offset_est [AXES] = '{default: '0};
    logic [SUM_W-1:0]    sum_est [AXES] = '{default: '0};
    logic [COUNT_W-1:0]  seen_est = '0;

    imu_offset_calibrate_compensate u_top (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // reset, once
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("** imu_offset_calibrate_compensate: FAILED **");
        $finish;
    end

    // compensates one frame and updates the calibration state;
    // returns 0 for a stale frame, which leaves everything untouched
    function automatic bit compensate_frame(input frame_t f, output comp_frame_t r);
        int divisor;
        int quot;
        r = '0;
        if (f.raw[0][7:0] == 8'h00)
            return 1'b0;
        for (int a = 0; a < AXES; a++)
            r.comp[a] = f.raw[a] - offset_est[a];
        if (f.kind == KIND_CAL)
        begin
            divisor = (count_cfg == '0) ? 1 : int'(count_cfg);
            for (int a = 0; a < AXES; a++)
                sum_est[a] = sum_est[a] + {{(SUM_W-SAMPLE_W){r.comp[a][SAMPLE_W-1]}}, r.comp[a]};
            seen_est = seen_est + 1'b1;
            if (int'(seen_est) >= divisor || seen_est == '0)
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    // integer division truncates toward zero
                    quot = int'($signed(sum_est[a])) / divisor;
                    offset_est[a] = quot[SAMPLE_W-1:0];
                    sum_est[a] = '0;
                end
                // keep one g in the z reading
                offset_est[AXIS_ACCEL_Z] = offset_est[AXIS_ACCEL_Z]
                    - SAMPLE_W'(int'(ONE_G_BASE) << range_cfg);
                seen_est = '0;
                r.done = 1'b1;
            end
        end
        return 1'b1;
    endfunction

    // input driver: a new frame only once the last one is transferred
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (frames_to_send.size() != 0 && $urandom_range(99) >= in_idle_pct)
            begin
                drive_frame = frames_to_send.pop_front();
                in_valid    <= 1'b1;
                kind        <= drive_frame.kind;
                accel_x_raw <= drive_frame.raw[0];
                accel_y_raw <= drive_frame.raw[1];
                accel_z_raw <= drive_frame.raw[2];
                gyro_x_raw  <= drive_frame.raw[3];
                gyro_y_raw  <= drive_frame.raw[4];
                gyro_z_raw  <= drive_frame.raw[5];
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output side readiness, with random stalls and the long hold-off
    always @(negedge clk)
        out_ready <= !rx_hold && ($urandom_range(99) >= out_stall_pct);

    // long receiver hold-off, counted here so the sender keeps offering
    initial
    begin
        wait (hold_request);
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    // monitor: register writes, input transfers and result checks
    always @(posedge clk)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= in_valid && in_ready;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_CALIB_COUNT: count_cfg = cfg_data[COUNT_W-1:0];
                    CFG_RANGE_SEL:   range_cfg = cfg_data[RANGE_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                frames_accepted++;
                taken_frame.kind   = kind;
                taken_frame.raw[0] = accel_x_raw;
                taken_frame.raw[1] = accel_y_raw;
                taken_frame.raw[2] = accel_z_raw;
                taken_frame.raw[3] = gyro_x_raw;
                taken_frame.raw[4] = gyro_y_raw;
                taken_frame.raw[5] = gyro_z_raw;
                if (compensate_frame(taken_frame, predicted))
                    pending_comp.push_back(predicted);
            end
            if (out_valid && out_ready)
            begin
                got.comp[0] = accel_x_comp;
                got.comp[1] = accel_y_comp;
                got.comp[2] = accel_z_comp;
                got.comp[3] = gyro_x_comp;
                got.comp[4] = gyro_y_comp;
                got.comp[5] = gyro_z_comp;
                got.done    = calib_done;
                if (pending_comp.size() == 0)
                begin
                    $error("result transfer with no frame pending");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_comp.pop_front();
                    for (int a = 0; a < AXES; a++)
                    begin
                        if (got.comp[a] !== want.comp[a])
                        begin
                            $error("%s: expected %0d, actual %0d", comp_name[a],
                                   $signed(want.comp[a]), $signed(got.comp[a]));
                            mismatch_count++;
                        end
                    end
                    if (got.done !== want.done)
                    begin
                        $error("calib_done: expected %0d, actual %0d", want.done, got.done);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    function automatic frame_t frame_of(input logic k, input logic [15:0] ax, ay, az,
                                        input logic [15:0] gx, gy, gz);
        frame_t f;
        f.kind = k;
        f.raw  = {gz, gy, gx, az, ay, ax};
        return f;
    endfunction

    // sample near the phase bias, or anywhere in the full range
    function automatic frame_t make_frame(input logic k, input bit full_range);
        frame_t f;
        f.kind = k;
        for (int a = 0; a < AXES; a++)
        begin
            if (full_range)
                f.raw[a] = SAMPLE_W'($urandom);
            else
                f.raw[a] = axis_bias[a] + SAMPLE_W'($urandom_range(255)) - 16'd128;
        end
        if (!full_range && f.raw[0][7:0] == 8'h00)
            f.raw[0][7:0] = 8'h01;
        return f;
    endfunction

    function automatic frame_t make_stale(input logic k);
        frame_t f;
        f = make_frame(k, 1'b1);
        f.raw[0][7:0] = 8'h00;
        return f;
    endfunction

    task automatic queue_frame(input frame_t f);
        frames_to_send.push_back(f);
        frames_queued++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // wait for every frame to be transferred and every result to arrive,
    // then let a stale frame still in the pipe finish
    task automatic drain_block();
        while (frames_accepted != frames_queued || pending_comp.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // one random phase: calibration runs with measurements after, plus noise
    task automatic random_phase(input int p);
        logic [COUNT_W-1:0] count_val;
        int run_len;
        int queued_now;
        drain_block();
        case (p)
            3:       count_val = 16'd20;
            5:       count_val = 16'hFFFF;
            9:       count_val = 16'd0;
            default: count_val = COUNT_W'($urandom_range(1, 6));
        endcase
        write_reg(CFG_CALIB_COUNT, count_val);
        write_reg(CFG_RANGE_SEL, {13'($urandom), 3'($urandom_range(0, 7))});
        case (p % 4)
            0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
            1:       begin in_idle_pct = 49; out_stall_pct = 0;  end
            2:       begin in_idle_pct = 0;  out_stall_pct = 49; end
            default: begin in_idle_pct = 14; out_stall_pct = 14; end
        endcase
        for (int a = 0; a < AXES; a++)
            axis_bias[a] = SAMPLE_W'($urandom);
        if (p == 0)
            hold_request = 1'b1;
        queued_now = 0;
        while (queued_now < PHASE_FRAMES)
        begin
            if ($urandom_range(9) < 7)
            begin
                run_len = (count_val == '0) ? 1 :
                          (count_val > 24) ? $urandom_range(1, 8) : int'(count_val);
                for (int i = 0; i < run_len; i++)
                begin
                    if ($urandom_range(9) == 0)
                        queue_frame(make_stale(1'($urandom_range(1))));
                    if ($urandom_range(14) == 0)
                    begin
                        queue_frame(make_frame(KIND_MEAS, 1'b0));
                        queued_now++;
                    end
                    queue_frame(make_frame(KIND_CAL, $urandom_range(19) == 0));
                    queued_now++;
                end
                repeat ($urandom_range(1, 4))
                begin
                    queue_frame(make_frame(KIND_MEAS, 1'b0));
                    queued_now++;
                end
            end
            else
            begin
                queue_frame(make_frame(1'($urandom_range(1)), 1'b1));
                queued_now++;
            end
        end
    endtask

    // stimulus
    initial
    begin
        wait (rst_n);

        // extremes of the fields and stale frames, default registers
        queue_frame(frame_of(KIND_MEAS, 16'h0001, 16'h0000, 16'h0000,
                             16'h0000, 16'h0000, 16'h0000));
        queue_frame(frame_of(KIND_MEAS, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                             16'h7FFF, 16'h7FFF, 16'h7FFF));
        queue_frame(frame_of(KIND_MEAS, 16'h80FF, 16'h8000, 16'h8000,
                             16'h8000, 16'h8000, 16'h8000));
        queue_frame(frame_of(KIND_MEAS, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                             16'hFFFF, 16'hFFFF, 16'hFFFF));
        queue_frame(frame_of(KIND_MEAS, 16'h55AA, 16'hAA55, 16'h55AA,
                             16'hAA55, 16'h55AA, 16'hAA55));
        queue_frame(frame_of(KIND_MEAS, 16'h8000, 16'h7FFF, 16'h7FFF,
                             16'h7FFF, 16'h7FFF, 16'h7FFF));
        queue_frame(frame_of(KIND_CAL, 16'h1200, 16'h1111, 16'h2222,
                             16'h3333, 16'h4444, 16'h5555));

        // two-frame calibration, negative odd sum truncates toward zero,
        // a stale calibration frame in between must not count
        drain_block();
        write_reg(CFG_CALIB_COUNT, 16'd2);
        write_reg(CFG_RANGE_SEL, 16'd1);
        queue_frame(frame_of(KIND_CAL, 16'h0101, 16'hFFFD, 16'h0800,
                             16'h0011, 16'hFFF0, 16'h7FFF));
        queue_frame(frame_of(KIND_CAL, 16'h0100, 16'h0123, 16'h0456,
                             16'h0789, 16'h0ABC, 16'h0DEF));
        queue_frame(frame_of(KIND_CAL, 16'h0103, 16'hFFFE, 16'h0801,
                             16'h0012, 16'hFFF1, 16'h7FFF));
        queue_frame(frame_of(KIND_MEAS, 16'h0102, 16'h0000, 16'h0000,
                             16'h0000, 16'h0000, 16'h0000));
        queue_frame(frame_of(KIND_MEAS, 16'h80FF, 16'h8000, 16'h8000,
                             16'h8000, 16'h8000, 16'h8000));

        // zero count acts as one; range select five wraps the gravity term
        drain_block();
        write_reg(CFG_CALIB_COUNT, 16'd0);
        write_reg(CFG_RANGE_SEL, 16'd5);
        queue_frame(frame_of(KIND_CAL, 16'h0201, 16'h7FFF, 16'h8000,
                             16'h1234, 16'hEDCB, 16'h0000));
        queue_frame(frame_of(KIND_MEAS, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                             16'h7FFF, 16'h7FFF, 16'h7FFF));

        // range selects six and seven give no gravity term
        drain_block();
        write_reg(CFG_RANGE_SEL, 16'hFFFE);
        queue_frame(frame_of(KIND_CAL, 16'h00FF, 16'h0001, 16'h4000,
                             16'h0000, 16'h0000, 16'h8000));
        drain_block();
        write_reg(CFG_RANGE_SEL, 16'h0007);
        queue_frame(frame_of(KIND_CAL, 16'h0F01, 16'hC000, 16'h3FFF,
                             16'h8001, 16'h0100, 16'hFF00));
        queue_frame(frame_of(KIND_MEAS, 16'h0F01, 16'hC000, 16'h3FFF,
                             16'h8001, 16'h0100, 16'hFF00));

        // count lowered below the frames already seen completes at once
        drain_block();
        write_reg(CFG_CALIB_COUNT, 16'hFFFF);
        write_reg(CFG_RANGE_SEL, 16'd4);
        queue_frame(frame_of(KIND_CAL, 16'h0011, 16'h0022, 16'h4033,
                             16'h0044, 16'h0055, 16'h0066));
        queue_frame(frame_of(KIND_CAL, 16'hFF11, 16'hFF22, 16'h3F33,
                             16'hFF44, 16'hFF55, 16'hFF66));
        queue_frame(frame_of(KIND_CAL, 16'h0013, 16'hFFFF, 16'h4000,
                             16'h0001, 16'h8000, 16'h7FFF));
        drain_block();
        write_reg(CFG_CALIB_COUNT, 16'd2);
        queue_frame(frame_of(KIND_CAL, 16'h0021, 16'h0001, 16'h4001,
                             16'hFFFF, 16'h0002, 16'hFFFE));
        queue_frame(frame_of(KIND_MEAS, 16'h0021, 16'h0001, 16'h4001,
                             16'hFFFF, 16'h0002, 16'hFFFE));

        for (int p = 0; p < RANDOM_PHASES; p++)
            random_phase(p);

        // wait out the last results and watch for stray ones
        while (frames_accepted != frames_queued || pending_comp.size() != 0)
            @(negedge clk);
        repeat (END_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("** imu_offset_calibrate_compensate: PASSED **");
        else
            $display("** imu_offset_calibrate_compensate: FAILED **");
        $finish;
    end

endmodule
